// ----- rtl/tln_pkg.sv -----
// Package for the tactile level normalizer: widths, register indexes, payload types.
// No dependencies.
package tln_pkg;
  localparam int SampleBits = 12;
  localparam int FracBits = 12;
  localparam int LevelBits = SampleBits + FracBits;
  localparam int GainBits = 16;
  localparam int NormBits = 16;
  localparam int QuoBits = 16;

  localparam logic [2:0] REG_MEAN_GAIN = 3'd0;
  localparam logic [2:0] REG_RANGE_GAIN = 3'd1;
  localparam logic [2:0] REG_RELEASE_DECAY = 3'd2;
  localparam logic [2:0] REG_OUTPUT_MODE = 3'd3;
  localparam logic [2:0] REG_ABS_LOW_START = 3'd4;
  localparam logic [2:0] REG_ABS_HIGH_START = 3'd5;

  localparam logic [15:0] TENTH_Q16 = 16'd6554;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic sample_valid;
  } in_t;

  typedef struct packed {
    logic [LevelBits-1:0] raw_level;
    logic signed [NormBits-1:0] norm_level;
    logic release_active;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input, start update
    logic upd_a;     // first update step
    logic upd_b;     // second update step
    logic upd_c;     // release step
    logic div_start; // set up normalization division
    logic div_step;  // one quotient bit
    logic finish;    // form result
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;
endpackage

// ----- rtl/tln_ctrl.sv -----
// Controller for the tactile level normalizer: sequences update, divide and output.
// Depends on tln_pkg.
module tln_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  tln_pkg::sts_t sts,
  output tln_pkg::cmd_t cmd
);
  import tln_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPA = 3'd1;
  localparam logic [2:0] S_UPB = 3'd2;
  localparam logic [2:0] S_UPC = 3'd3;
  localparam logic [2:0] S_DSET = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_FIN = 3'd6;

  logic [2:0] state, state_next;
  logic out_full;

  assign in_stall = (state != S_IDLE);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_UPA;
        end
      end
      S_UPA: begin
        cmd.upd_a = 1'b1;
        state_next = S_UPB;
      end
      S_UPB: begin
        cmd.upd_b = 1'b1;
        state_next = S_UPC;
      end
      S_UPC: begin
        cmd.upd_c = 1'b1;
        state_next = S_DSET;
      end
      S_DSET: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_full || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_full <= 1'b1;
      else if (!out_stall) out_full <= 1'b0;
    end
  end
endmodule

// ----- rtl/tln_datapath.sv -----
// Datapath for the tactile level normalizer: state registers, gains, serial divider.
// Depends on tln_pkg.
module tln_datapath (
  input  logic clk,
  input  logic rst,
  input  tln_pkg::in_t in_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [tln_pkg::GainBits-1:0] cfg_data,
  input  tln_pkg::cmd_t cmd,
  output tln_pkg::sts_t sts,
  output tln_pkg::out_t out_data
);
  import tln_pkg::*;

  localparam int LB = LevelBits;
  localparam int DivW = LB + 16; // dividend width for (diff << 15)

  logic [15:0] mean_gain, range_gain, release_decay;
  logic [2:0] output_mode;

  logic [SampleBits-1:0] current_sample, all_time_low, all_time_high, smp;
  logic [LB-1:0] mean_level, sliding_low, sliding_high, held_release_level;
  logic release_flag, valid_q;
  logic [LB-1:0] prev_lv;

  logic [LB-1:0] lv;
  assign lv = {smp, {FracBits{1'b0}}};

  // step A products
  logic [LB-1:0] sl_w, sh_w;
  assign sl_w = (lv < sliding_low) ? lv : sliding_low;
  assign sh_w = (lv > sliding_high) ? lv : sliding_high;
  logic [16:0] gain_inv;
  assign gain_inv = 17'h10000 - {1'b0, mean_gain};
  logic [LB+16:0] mean_sum;
  assign mean_sum = {17'd0, mean_level} * {{(LB+1){1'b0}}, mean_gain};
  logic [LB+16:0] mean_p1, mean_p2;
  logic [LB+15:0] rl_p, rh_p;
  logic [LB-1:0] sl_dist, sh_dist;
  assign sl_dist = lv - sl_w;
  assign sh_dist = sh_w - lv;

  // step B/C
  logic [LB-1:0] absr, dynr, delta;
  logic [LB+15:0] delta_p, dec_p;
  assign absr = (all_time_high > all_time_low)
              ? {all_time_high - all_time_low, {FracBits{1'b0}}} : '0;
  assign dynr = (sliding_high > sliding_low) ? sliding_high - sliding_low : '0;
  assign delta_p = {16'd0, absr} * {{LB{1'b0}}, TENTH_Q16} + (LB+16)'(32768);
  assign delta = delta_p[LB+15:16];
  assign dec_p = {16'd0, dynr} * {{LB{1'b0}}, release_decay} + (LB+16)'(32768);

  // divider
  logic [DivW-1:0] dividend;
  logic [LB-1:0] rem;
  logic [LB-1:0] divisor;
  logic [QuoBits+1:0] quo;
  logic [5:0] dcnt;
  logic dneg, dzero, dflip;
  logic [LB:0] rem_sh, rem_sub;
  assign rem_sh = {rem, dividend[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign sts.div_last = (dcnt == 6'd0);

  // normalization operand selection
  logic [LB-1:0] x_sel, base_sel, rng_sel, op_a;
  logic use_rel, zero_sel;
  logic [LB:0] diff;
  logic d_neg;
  logic [LB-1:0] d_mag;
  always_comb begin
    x_sel = output_mode[0] ? mean_level : {current_sample, {FracBits{1'b0}}};
    use_rel = output_mode[2] & output_mode[1] & release_flag;
    op_a = use_rel ? held_release_level : x_sel;
    if (output_mode[2]) begin
      base_sel = sliding_low;
      rng_sel = dynr;
      zero_sel = (absr == '0) || (dynr == '0);
    end else begin
      base_sel = {all_time_low, {FracBits{1'b0}}};
      rng_sel = absr;
      zero_sel = (absr == '0);
    end
    if (output_mode[2:1] == 2'b00) zero_sel = 1'b1;
    diff = {1'b0, op_a} - {1'b0, base_sel};
    d_neg = diff[LB];
    d_mag = d_neg ? LB'(-diff) : diff[LB-1:0];
  end

  // quotient saturation; release path negates the value again
  logic signed [17:0] qs, qfin;
  always_comb begin
    logic [QuoBits+1:0] qm;
    qm = quo;
    if (dneg) begin
      qs = (qm > 18'd32768) ? -18'sd32768 : -$signed(qm);
    end else begin
      qs = (qm > 18'd32767) ? 18'sd32767 : $signed(qm);
    end
    qfin = dflip ? -qs : qs;
    if (qfin > 18'sd32767) qfin = 18'sd32767;
    if (dzero) qfin = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_gain <= 16'd45875;
      range_gain <= 16'd65503;
      release_decay <= 16'd3277;
      output_mode <= 3'd2;
      current_sample <= '0;
      mean_level <= '0;
      all_time_low <= '1;
      all_time_high <= '0;
      sliding_low <= '1;
      sliding_high <= '0;
      held_release_level <= '0;
      release_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MEAN_GAIN: mean_gain <= cfg_data;
          REG_RANGE_GAIN: range_gain <= cfg_data;
          REG_RELEASE_DECAY: release_decay <= cfg_data;
          REG_OUTPUT_MODE: output_mode <= cfg_data[2:0];
          REG_ABS_LOW_START: all_time_low <= cfg_data[SampleBits-1:0];
          REG_ABS_HIGH_START: all_time_high <= cfg_data[SampleBits-1:0];
          default: ;
        endcase
      end
      if (cmd.upd_b && valid_q) begin
        mean_level <= LB'((mean_p1 + mean_p2 + (LB+17)'(32768)) >> 16);
        sliding_low <= lv - LB'((rl_p + (LB+16)'(32768)) >> 16);
        sliding_high <= lv + LB'((rh_p + (LB+16)'(32768)) >> 16);
        if (smp < all_time_low) all_time_low <= smp;
        if (smp > all_time_high) all_time_high <= smp;
      end
      if (cmd.upd_c && valid_q) begin
        current_sample <= smp;
        if (release_flag && ({1'b0, lv} > {1'b0, prev_lv} + {1'b0, delta})) begin
          release_flag <= 1'b0;
          held_release_level <= '0;
        end else if ({1'b0, lv} + {1'b0, delta} < {1'b0, prev_lv}) begin
          release_flag <= 1'b1;
          held_release_level <= prev_lv;
        end else if (release_flag) begin
          if ({1'b0, held_release_level} < {1'b0, dec_p[LB+15:16]} + {1'b0, sliding_low}) begin
            release_flag <= 1'b0;
            held_release_level <= '0;
          end else begin
            held_release_level <= held_release_level - dec_p[LB+15:16];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= in_data.sample;
      valid_q <= in_data.sample_valid;
      prev_lv <= {current_sample, {FracBits{1'b0}}};
    end
    if (cmd.upd_a) begin
      mean_p1 <= mean_sum;
      mean_p2 <= {17'd0, lv} * {{LB{1'b0}}, gain_inv};
      rl_p <= {16'd0, sl_dist} * {{LB{1'b0}}, range_gain};
      rh_p <= {16'd0, sh_dist} * {{LB{1'b0}}, range_gain};
    end
    if (cmd.div_start) begin
      dividend <= {1'b0, d_mag, 15'd0};
      divisor <= (rng_sel == '0) ? LB'(1) : rng_sel;
      rem <= '0;
      quo <= '0;
      dcnt <= 6'(DivW - 1);
      dneg <= d_neg;
      dflip <= use_rel;
      dzero <= zero_sel;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[DivW-2:0], 1'b0};
      if (!rem_sub[LB]) begin
        rem <= rem_sub[LB-1:0];
        quo <= (quo[QuoBits+1] || quo[QuoBits]) ? quo | {2'b10, 16'd0}
               : {quo[QuoBits:0], 1'b1};
      end else begin
        rem <= rem_sh[LB-1:0];
        quo <= (quo[QuoBits+1] || quo[QuoBits]) ? quo | {2'b10, 16'd0}
               : {quo[QuoBits:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
    if (cmd.finish) begin
      out_data.raw_level <= x_sel;
      out_data.norm_level <= qfin[15:0];
      out_data.release_active <= release_flag;
    end
  end
endmodule

// ----- rtl/tactile_level_normalizer_core.sv -----
// Top level of the tactile level normalizer: joins controller and datapath.
// Depends on tln_pkg, tln_ctrl, tln_datapath.
//
// Usage: one input transaction (sample, sample_valid) per tactile cell reading.
// sample_valid low leaves the tracking state alone but still yields a result.
// Every input transaction gives exactly one output transaction carrying the raw
// level, the Q1.15 normalized level and the release flag.
// Sequence: after the accepting edge the item passes the update steps
// (products are registered before use), the divider setup, the bit-serial
// restoring divider (one quotient bit per cycle over the 40-bit shifted
// difference) and the step that forms the result; out_valid then rises.
// The core takes one transaction at a time; in_stall is high while an item
// is in work. The output register frees the core as soon as the result is
// loaded; a stalled receiver holds the result and the next result waits in
// the final step until the register is taken.
// Reset (rst, synchronous) loads the configuration and tracking registers to
// their defaults and empties the all-time range. Configuration writes are
// taken any cycle and should be done while idle.
module tactile_level_normalizer_core (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  tln_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output tln_pkg::out_t out_data,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [tln_pkg::GainBits-1:0] cfg_data
);
  import tln_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tln_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  tln_datapath u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );
endmodule

// ----- dv/testbench.sv -----
// Testbench for tactile_level_normalizer_core: random and directed samples,
// a built-in predictor of the level tracking and normalization, per-field checks.
// Depends on tln_pkg and the RTL of the core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tln_pkg::*;

  localparam int IdleLimit = 20000;
  localparam logic [2:0] RegUnusedLo = 3'd6;
  localparam logic [2:0] RegUnusedHi = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [GainBits-1:0] cfg_data = '0;

  tactile_level_normalizer_core uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  longint unsigned g_mean, g_range, g_decay, g_mode, lo_start, hi_start;
  longint unsigned cur_smp, mean_lvl, at_low, at_high, sl_low, sl_high, held;
  bit rel_flag;

  in_t pending_samples[$];
  out_t expected_levels[$];
  int errors = 0;
  int gap_mode = 0;       // 0 random gaps, 1 none
  int hold_cycles = 0;    // long receiver hold-off, counted by the monitor
  bit stim_done = 0;

  function automatic longint tracker_div(longint diff, longint unsigned rng);
    longint unsigned mag, q;
    mag = (diff < 0) ? -diff : diff;
    q = (mag << 15) / rng;
    if (diff < 0) begin
      if (q > 32768) q = 32768;
      return -longint'(q);
    end
    if (q > 32767) q = 32767;
    return longint'(q);
  endfunction

  function automatic void tracker_reset();
    g_mean = 45875; g_range = 65503; g_decay = 3277; g_mode = 2;
    lo_start = 4095; hi_start = 0;
    cur_smp = 0; mean_lvl = 0; at_low = lo_start; at_high = hi_start;
    sl_low = 24'hFFFFFF; sl_high = 0; held = 0; rel_flag = 0;
  endfunction

  function automatic void tracker_config(logic [2:0] idx, longint unsigned v);
    case (idx)
      REG_MEAN_GAIN: g_mean = v & 16'hFFFF;
      REG_RANGE_GAIN: g_range = v & 16'hFFFF;
      REG_RELEASE_DECAY: g_decay = v & 16'hFFFF;
      REG_OUTPUT_MODE: g_mode = v & 7;
      REG_ABS_LOW_START: begin lo_start = v & 12'hFFF; at_low = lo_start; end
      REG_ABS_HIGH_START: begin hi_start = v & 12'hFFF; at_high = hi_start; end
      default: ;
    endcase
  endfunction

  function automatic out_t track_sample(in_t it);
    longint unsigned lv, prev, absr, dynr, delta, x;
    longint h, norm;
    out_t r;
    norm = 0;
    if (it.sample_valid) begin
      lv = longint'(it.sample) << FracBits;
      prev = cur_smp << FracBits;
      mean_lvl = ((g_mean * mean_lvl + (65536 - g_mean) * lv + 32768) >> 16) & 24'hFFFFFF;
      if (it.sample < at_low) at_low = it.sample;
      if (it.sample > at_high) at_high = it.sample;
      if (lv < sl_low) sl_low = lv;
      if (lv > sl_high) sl_high = lv;
      sl_low = lv - ((g_range * (lv - sl_low) + 32768) >> 16);
      sl_high = lv + ((g_range * (sl_high - lv) + 32768) >> 16);
      absr = at_high > at_low ? (at_high - at_low) << FracBits : 0;
      dynr = sl_high > sl_low ? sl_high - sl_low : 0;
      delta = (absr * 6554 + 32768) >> 16;
      if (rel_flag && longint'(lv) > longint'(prev) + longint'(delta)) begin
        rel_flag = 0; held = 0;
      end else if (longint'(lv) < longint'(prev) - longint'(delta)) begin
        rel_flag = 1; held = prev;
      end else if (rel_flag) begin
        h = longint'(held) - longint'((g_decay * dynr + 32768) >> 16);
        if (h < longint'(sl_low)) begin
          rel_flag = 0; held = 0;
        end else held = longint'(h) & 24'hFFFFFF;
      end
      cur_smp = it.sample;
    end
    x = g_mode[0] ? mean_lvl : (cur_smp << FracBits);
    if (g_mode >= 2) begin
      absr = at_high > at_low ? (at_high - at_low) << FracBits : 0;
      if (absr != 0) begin
        if (g_mode < 4) norm = tracker_div(longint'(x) - longint'(at_low << FracBits), absr);
        else begin
          dynr = sl_high > sl_low ? sl_high - sl_low : 0;
          if (dynr != 0) begin
            if (g_mode >= 6 && rel_flag)
              norm = -tracker_div(longint'(held) - longint'(sl_low), dynr);
            else
              norm = tracker_div(longint'(x) - longint'(sl_low), dynr);
            if (norm > 32767) norm = 32767;
          end
        end
      end
    end
    r.raw_level = x[LevelBits-1:0];
    r.norm_level = norm[15:0];
    r.release_active = rel_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (gap_mode == 1 || p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_levels.push_back(track_sample(in_data));
        void'(pending_samples.pop_front());
        send_gap = pick_gap();
      end
      if (send_gap > 0 && !(in_valid && in_stall)) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (in_valid && in_stall) begin
        // hold the payload
      end else if (pending_samples.size() > 0 && !(in_valid && !in_stall &&
                   pending_samples.size() == 0)) begin
        in_valid <= 1'b1;
        in_data <= pending_samples[0];
      end else in_valid <= 1'b0;
    end
  end

  // monitor
  int recv_gap = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (expected_levels.size() == 0) begin
          $error("unexpected transaction raw_level=%0h", out_data.raw_level);
          errors++;
        end else begin
          out_t e;
          e = expected_levels.pop_front();
          if (e.raw_level !== out_data.raw_level) begin
            $error("raw_level expected %0h got %0h", e.raw_level, out_data.raw_level); errors++;
          end
          if (e.norm_level !== out_data.norm_level) begin
            $error("norm_level expected %0d got %0d", e.norm_level, out_data.norm_level);
            errors++;
          end
          if (e.release_active !== out_data.release_active) begin
            $error("release_active expected %0b got %0b", e.release_active,
                   out_data.release_active);
            errors++;
          end
        end
        recv_gap = pick_gap();
      end else if (in_valid && !in_stall) idle_cycles = 0;
      else idle_cycles++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        idle_cycles = 0;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic push_sample(logic [11:0] s, bit v);
    in_t it;
    it.sample = s;
    it.sample_valid = v;
    pending_samples.push_back(it);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_levels.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // each write is followed by an idle wait with cfg_we low, so writes never run back to back
  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker_config(idx, v);
    @(posedge clk);
  endtask

  // well-formed press/release shapes with random content, some noise
  task automatic random_phase(int n);
    int k, len;
    logic [11:0] base, peak;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 3) == 0) begin
        push_sample(12'($urandom), $urandom_range(0, 5) != 0); k++;
      end else begin
        base = 12'($urandom_range(0, 800));
        peak = 12'($urandom_range(1500, 4095));
        len = $urandom_range(2, 8);
        for (int i = 0; i < len; i++) begin
          push_sample(12'(peak - $urandom_range(0, 200)), 1'b1); k++;
        end
        for (int i = 0; i < len; i++) begin
          push_sample(12'(base + $urandom_range(0, 100)), $urandom_range(0, 9) != 0); k++;
        end
      end
    end
    drain();
  endtask

  initial begin
    tracker_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, invalid samples, drops and rises, every mode
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_OUTPUT_MODE, 16'(m));
      push_sample(12'd0, 1'b0);
      push_sample(12'hFFF, 1'b1);
      push_sample(12'd0, 1'b1);
      push_sample(12'd2000, 1'b0);
      push_sample(12'hFFF, 1'b1);
      push_sample(12'd100, 1'b1);
      push_sample(12'd90, 1'b1);
      push_sample(12'h555, 1'b1);
      push_sample(12'hAAA, 1'b1);
      drain();
      if (m == 2) begin
        write_reg(RegUnusedLo, 16'hFFFF);
        write_reg(RegUnusedHi, 16'h0000);
      end
    end
    // empty all-time range
    write_reg(REG_ABS_LOW_START, 16'd4095);
    write_reg(REG_ABS_HIGH_START, 16'd0);
    write_reg(REG_OUTPUT_MODE, 3);
    push_sample(12'd7, 1'b0);
    push_sample(12'd7, 1'b1);
    drain();
    // sender floods while the receiver holds off
    gap_mode = 1;
    write_reg(REG_OUTPUT_MODE, 6);
    hold_cycles = 600;
    random_phase(40);
    gap_mode = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_MEAN_GAIN, 0); write_reg(REG_RANGE_GAIN, 0);
                 write_reg(REG_RELEASE_DECAY, 0); end
        1: begin write_reg(REG_MEAN_GAIN, 16'hFFFF); write_reg(REG_RANGE_GAIN, 16'hFFFF);
                 write_reg(REG_RELEASE_DECAY, 16'hFFFF); end
        2: begin write_reg(REG_ABS_LOW_START, 0); write_reg(REG_ABS_HIGH_START, 16'hFFF); end
        3: begin write_reg(REG_MEAN_GAIN, 45875); write_reg(REG_RANGE_GAIN, 65503);
                 write_reg(REG_RELEASE_DECAY, 3277);
                 write_reg(REG_ABS_LOW_START, 16'hFFF); write_reg(REG_ABS_HIGH_START, 0); end
        default: begin write_reg(REG_MEAN_GAIN, 16'($urandom));
                 write_reg(REG_RANGE_GAIN, 16'($urandom));
                 write_reg(REG_RELEASE_DECAY, 16'($urandom_range(0, 20000))); end
      endcase
      write_reg(REG_OUTPUT_MODE, 16'($urandom_range(0, 7)));
      if (ph == 4) write_reg(REG_OUTPUT_MODE, 7);
      if (ph == 5) write_reg(REG_OUTPUT_MODE, 6);
      random_phase(130);
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0 && expected_levels.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
